@@ rtl/core/md2_pkg.sv @@
// ----------------------------------------------------------------------------
// md2_pkg
// Shared constants, S-box table and control structs of the MD2 hash unit.
// ----------------------------------------------------------------------------
package md2_pkg;

  localparam int MD2_BLOCK  = 16;
  localparam int MD2_STATE  = 48;
  localparam int MD2_ROUNDS = 18;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic start;
    logic load;
    logic clear;
  } mix_ctrl_t;

  typedef struct packed {
    logic update;
    logic rotate;
    logic clear;
  } ck_ctrl_t;

  localparam byte_t SBOX [256] = '{
    8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1, 8'd61, 8'd54,
    8'd84, 8'd161, 8'd236, 8'd240, 8'd6, 8'd19, 8'd98, 8'd167, 8'd5, 8'd243,
    8'd192, 8'd199, 8'd115, 8'd140, 8'd152, 8'd147, 8'd43, 8'd217, 8'd188,
    8'd76, 8'd130, 8'd202, 8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212,
    8'd224, 8'd22, 8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229,
    8'd18, 8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122, 8'd169,
    8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63, 8'd148, 8'd194,
    8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33, 8'd128, 8'd127, 8'd93,
    8'd154, 8'd90, 8'd144, 8'd50, 8'd39, 8'd53, 8'd62, 8'd204, 8'd231,
    8'd191, 8'd247, 8'd151, 8'd3, 8'd255, 8'd25, 8'd48, 8'd179, 8'd72,
    8'd165, 8'd181, 8'd209, 8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86,
    8'd170, 8'd198, 8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125,
    8'd182, 8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
    8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32, 8'd134,
    8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2, 8'd27, 8'd96,
    8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246, 8'd28, 8'd70, 8'd97,
    8'd105, 8'd52, 8'd64, 8'd126, 8'd15, 8'd85, 8'd71, 8'd163, 8'd35,
    8'd221, 8'd81, 8'd175, 8'd58, 8'd195, 8'd92, 8'd249, 8'd206, 8'd186,
    8'd197, 8'd234, 8'd38, 8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40,
    8'd132, 8'd9, 8'd211, 8'd223, 8'd205, 8'd244, 8'd65, 8'd129, 8'd77,
    8'd82, 8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74, 8'd120,
    8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109, 8'd233, 8'd203,
    8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57, 8'd242, 8'd239, 8'd183,
    8'd14, 8'd102, 8'd88, 8'd208, 8'd228, 8'd166, 8'd119, 8'd114, 8'd248,
    8'd235, 8'd117, 8'd75, 8'd10, 8'd49, 8'd68, 8'd80, 8'd180, 8'd143,
    8'd237, 8'd31, 8'd26, 8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17,
    8'd131, 8'd20
  };

endpackage

@@ rtl/core/md2_cksum.sv @@
// ----------------------------------------------------------------------------
// md2_cksum
// Byte-serial checksum ring: folds one block byte per cycle while update is
// set into the 16-byte running checksum, or rotates it to feed the final block.
// ----------------------------------------------------------------------------
module md2_cksum
  import md2_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ck_ctrl_t ctrl_i,
  input  byte_t    byte_i,
  output byte_t    head_o
);

  byte_t cs_r   [MD2_BLOCK];
  byte_t cs_nxt [MD2_BLOCK];
  byte_t lc_r, lc_nxt;
  byte_t fold;

  assign head_o = cs_r[0];
  assign fold   = cs_r[0] ^ SBOX[byte_i ^ lc_r];

  always_comb begin
    cs_nxt = cs_r;
    lc_nxt = lc_r;
    if (ctrl_i.clear) begin
      for (int i = 0; i < MD2_BLOCK; i++) cs_nxt[i] = '0;
      lc_nxt = '0;
    end else if (ctrl_i.update || ctrl_i.rotate) begin
      for (int i = 0; i < MD2_BLOCK - 1; i++) cs_nxt[i] = cs_r[i+1];
      if (ctrl_i.update) begin
        cs_nxt[MD2_BLOCK-1] = fold;
        lc_nxt              = fold;
      end else begin
        cs_nxt[MD2_BLOCK-1] = cs_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MD2_BLOCK; i++) cs_r[i] <= '0;
      lc_r <= '0;
    end else begin
      cs_r <= cs_nxt;
      lc_r <= lc_nxt;
    end
  end

endmodule

@@ rtl/core/md2_mix.sv @@
// ----------------------------------------------------------------------------
// md2_mix
// Byte-serial 48-byte mixing chain: loads a block byte by byte, then runs
// 18 rounds of chained S-box substitution, one byte per cycle.
// ----------------------------------------------------------------------------
module md2_mix
  import md2_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  mix_ctrl_t      ctrl_i,
  input  byte_t          byte_i,
  output logic           done_o,
  output logic [127:0]   digest_o
);

  localparam logic [5:0] K_LAST = 6'(MD2_STATE - 1);
  localparam logic [4:0] R_LAST = 5'(MD2_ROUNDS - 1);

  byte_t      st_r   [MD2_STATE];
  byte_t      st_nxt [MD2_STATE];
  logic       run_r, run_nxt;
  logic [5:0] k_r, k_nxt;
  logic [4:0] r_r, r_nxt;
  byte_t      t_r, t_nxt;
  byte_t      sub;

  assign sub    = st_r[0] ^ SBOX[t_r];
  assign done_o = run_r && (k_r == K_LAST) && (r_r == R_LAST);

  always_comb begin
    for (int i = 0; i < MD2_BLOCK; i++) digest_o[127 - 8*i -: 8] = st_r[i];
  end

  always_comb begin
    st_nxt  = st_r;
    run_nxt = run_r;
    k_nxt   = k_r;
    r_nxt   = r_r;
    t_nxt   = t_r;
    if (ctrl_i.clear) begin
      for (int i = 0; i < MD2_STATE; i++) st_nxt[i] = '0;
      run_nxt = 1'b0;
    end else if (ctrl_i.load) begin
      for (int i = 0; i < MD2_BLOCK - 1; i++) begin
        st_nxt[i]               = st_r[i+1];
        st_nxt[MD2_BLOCK + i]   = st_r[MD2_BLOCK + i + 1];
        st_nxt[2*MD2_BLOCK + i] = st_r[2*MD2_BLOCK + i + 1];
      end
      st_nxt[MD2_BLOCK-1]   = st_r[0];
      st_nxt[2*MD2_BLOCK-1] = byte_i;
      st_nxt[MD2_STATE-1]   = byte_i ^ st_r[0];
    end else if (run_r) begin
      for (int i = 0; i < MD2_STATE - 1; i++) st_nxt[i] = st_r[i+1];
      st_nxt[MD2_STATE-1] = sub;
      t_nxt = sub;
      k_nxt = k_r + 6'd1;
      if (k_r == K_LAST) begin
        k_nxt = '0;
        t_nxt = sub + {3'b000, r_r};
        r_nxt = r_r + 5'd1;
        if (r_r == R_LAST) run_nxt = 1'b0;
      end
    end
    if (ctrl_i.start) begin
      run_nxt = 1'b1;
      k_nxt   = '0;
      r_nxt   = '0;
      t_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MD2_STATE; i++) st_r[i] <= '0;
      run_r <= 1'b0;
      k_r   <= '0;
      r_r   <= '0;
      t_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      run_r <= run_nxt;
      k_r   <= k_nxt;
      r_r   <= r_nxt;
      t_r   <= t_nxt;
    end
  end

endmodule

@@ rtl/core/md2_hash_unit.sv @@
// ----------------------------------------------------------------------------
// md2_hash_unit
// Streaming MD2 message digest, byte-serial datapath.
// ----------------------------------------------------------------------------
// An absorb beat shifts one byte in; every 16th byte starts block processing:
// the checksum is folded and the mixing chain loaded byte by byte, then the
// chain runs 18 rounds of 48 byte steps through one S-box lookup per cycle.
// A finish beat pads the block with 16 - n bytes of value 16 - n (n bytes
// held), processes the padded block, then the checksum block, and posts the
// digest once the output register is free; then the checksum, the mixing
// chain and the block counter are clear.
// in_ready is low while a block is being padded or processed and until the digest is posted.
module md2_hash_unit
  import md2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_high,
  output logic [63:0] out_digest_low
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_MIX  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic [4:0]   pad_r, pad_nxt;
  logic         fin_r, fin_nxt;
  logic         phase_r, phase_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [63:0]  hi_r, hi_nxt, lo_r, lo_nxt;
  byte_t        buf_r [MD2_BLOCK];
  byte_t        buf_nxt [MD2_BLOCK];
  logic         buf_shift;
  byte_t        buf_in;
  byte_t        src;
  byte_t        ck_head;
  logic         mix_done;
  logic [127:0] digest;
  mix_ctrl_t    mix_ctrl;
  ck_ctrl_t     ck_ctrl;
  logic         in_beat;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_beat         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_digest_high = hi_r;
  assign out_digest_low  = lo_r;
  assign src             = phase_r ? ck_head : buf_r[0];

  md2_cksum u_cksum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (ck_ctrl),
    .byte_i (src),
    .head_o (ck_head)
  );

  md2_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (mix_ctrl),
    .byte_i   (src),
    .done_o   (mix_done),
    .digest_o (digest)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pad_nxt       = pad_r;
    fin_nxt       = fin_r;
    phase_nxt     = phase_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    buf_shift     = 1'b0;
    buf_in        = buf_r[0];
    mix_ctrl      = '0;
    ck_ctrl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_op) begin
            pad_nxt   = 5'd16 - {1'b0, cnt_r};
            fin_nxt   = 1'b1;
            state_nxt = ST_PAD;
          end else begin
            buf_shift = 1'b1;
            buf_in    = in_data_byte;
            cnt_nxt   = cnt_r + 4'd1;
            if (cnt_r == 4'(MD2_BLOCK - 1)) begin
              idx_nxt   = '0;
              state_nxt = ST_LOAD;
            end
          end
        end
      end
      ST_PAD: begin
        buf_shift = 1'b1;
        buf_in    = {3'b000, pad_r};
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'(MD2_BLOCK - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        buf_shift      = 1'b1;
        mix_ctrl.load  = 1'b1;
        ck_ctrl.update = !phase_r;
        ck_ctrl.rotate = phase_r;
        idx_nxt        = idx_r + 4'd1;
        if (idx_r == 4'(MD2_BLOCK - 1)) begin
          mix_ctrl.start = 1'b1;
          state_nxt      = ST_MIX;
        end
      end
      ST_MIX: begin
        if (mix_done) begin
          if (phase_r) begin
            state_nxt = ST_DONE;
          end else if (fin_r) begin
            phase_nxt = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          hi_nxt         = digest[127:64];
          lo_nxt         = digest[63:0];
          out_valid_nxt  = 1'b1;
          mix_ctrl.clear = 1'b1;
          ck_ctrl.clear  = 1'b1;
          fin_nxt        = 1'b0;
          phase_nxt      = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    buf_nxt = buf_r;
    if (buf_shift) begin
      for (int i = 0; i < MD2_BLOCK - 1; i++) buf_nxt[i] = buf_r[i+1];
      buf_nxt[MD2_BLOCK-1] = buf_in;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    idx_r <= idx_nxt;
    pad_r <= pad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fin_r       <= fin_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/md2_chk.sv @@
// ----------------------------------------------------------------------------
// md2_chk
// Port-level checks of the MD2 hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module md2_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("digest beat pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("digest beat dropped before it was taken");

  a_finish_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("input ready right after a finish beat");

  a_no_fast_digest: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("digest posted right after an input beat");

endmodule

bind md2_hash_unit md2_chk u_md2_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
